/* design/pbpm_pkg.sv */
// Shared constants and helpers for the phosphor blend palette match block.
// No dependencies; imported by the top level.
package pbpm_pkg;

	// Palette geometry
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int RGB_W           = 24;
	localparam int CHAN_W          = 8;
	localparam int IDX_W           = 8;

	// Quantization of blended channels
	localparam int              QUANT_SHIFT = 2;
	localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;
	localparam logic [CHAN_W-1:0] QUANT_MASK = CHAN_W'(CHAN_MAX << QUANT_SHIFT);

	// Highest even palette index that the search visits
	localparam int LAST_EVEN = ((PALETTE_ENTRIES - 1) / 2) * 2;

	// Distance search: three channel differences summed
	localparam int               DIST_W     = 10;
	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 3 + 1);

	// Divide by 100 as multiply by reciprocal: exact for numerators below 91180
	localparam int PERCENT_DIV = 100;
	localparam int DIV_SHIFT   = 23;
	localparam int MUL_A_W     = 16;
	localparam int MUL_B_W     = 17;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int QUOT_W      = 10;
	localparam logic [MUL_B_W-1:0] DIV_MULT =
		MUL_B_W'(((1 << DIV_SHIFT) + PERCENT_DIV - 1) / PERCENT_DIV);

	// Configuration
	localparam int               CFG_W         = 8;
	localparam logic [CFG_W-1:0] BLEND_RESET   = 8'd77;

	// Stream widths
	localparam int IN_TDATA_W  = 48;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 8;

	// Request kinds carried in tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Channel select codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Pick one channel out of a packed entry (red high, blue low)
	function automatic logic [CHAN_W-1:0] chan_of(input logic [RGB_W-1:0] rgb,
			input logic [1:0] ch);
		logic [CHAN_W-1:0] v;
		unique case (ch)
			CH_RED:   v = rgb[23:16];
			CH_GREEN: v = rgb[15:8];
			default:  v = rgb[7:0];
		endcase
		return v;
	endfunction

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

/* design/pbpm_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; width and depth set by parameters.
module pbpm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read on one port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* design/phosphor_blend_palette_match.sv */
// Phosphor blend palette match, top level.
// Depends on pbpm_pkg and pbpm_ram.
//
// A write request (tuser = 0) stores one RGB palette entry. A pixel request
// (tuser = 1) is finished before the next request is accepted: S_RD_CUR,
// S_RD_PREV and S_LATCH fetch both palette entries; S_MUL, S_DIV and S_ACC blend
// each of the three channels in turn through one shared 16x17 multiplier (product,
// reciprocal divide, add and saturate); the nearest-colour search visits one even
// palette entry per cycle (128 at 256 entries) through the single RAM port; then
// a drain and an output load. The result sits in an output register, so the next
// request is taken while it waits to be read. Load every palette entry a pixel will
// touch, including all even entries, before sending pixels. The user must write
// blend_percent only while the block is idle; the block does not enforce it.
module phosphor_blend_palette_match (
	input  logic                                clk,
	input  logic                                arst_n,
	// cfg_data: blend_percent[7:0]
	input  logic                                cfg_we,
	input  logic [pbpm_pkg::CFG_W-1:0]          cfg_data,
	// s_tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24],
	//          current_index[39:32], previous_index[47:40]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pbpm_pkg::IN_TDATA_W-1:0]     s_tdata,
	// s_tuser: op[0]
	input  logic [pbpm_pkg::IN_TUSER_W-1:0]     s_tuser,
	// m_tdata: colour_index[7:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pbpm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	import pbpm_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_RD_CUR  = 10'b00_0000_0010,
		S_RD_PREV = 10'b00_0000_0100,
		S_LATCH   = 10'b00_0000_1000,
		S_MUL     = 10'b00_0001_0000,
		S_DIV     = 10'b00_0010_0000,
		S_ACC     = 10'b00_0100_0000,
		S_SEARCH  = 10'b00_1000_0000,
		S_DRAIN   = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Request fields
	logic              in_op;
	logic [IDX_W-1:0]  in_entry;
	logic [CHAN_W-1:0] in_red, in_green, in_blue;
	logic [IDX_W-1:0]  in_cur, in_prev;
	logic              in_fire;

	assign in_op    = s_tuser[0];
	assign in_entry = s_tdata[7:0];
	assign in_red   = s_tdata[15:8];
	assign in_green = s_tdata[23:16];
	assign in_blue  = s_tdata[31:24];
	assign in_cur   = s_tdata[39:32];
	assign in_prev  = s_tdata[47:40];

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// Configuration register
	logic [CFG_W-1:0] blend_percent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_percent_q <= BLEND_RESET;
		end else if (cfg_we) begin
			blend_percent_q <= cfg_data;
		end
	end

	// Palette RAM
	logic              ram_we;
	logic [PAL_AW-1:0] ram_addr;
	logic [RGB_W-1:0]  ram_wdata;
	logic [RGB_W-1:0]  ram_rdata;

	logic              entry_in_range;
	logic [PAL_AW-1:0] cur_q, prev_q;
	logic [PAL_AW-1:0] idx_q;

	assign entry_in_range = ({1'b0, in_entry} < (IDX_W + 1)'(PALETTE_ENTRIES));
	assign ram_we    = in_fire && (in_op == OP_WRITE) && entry_in_range;
	assign ram_wdata = {in_red, in_green, in_blue};

	always_comb begin
		unique case (state_q)
			S_IDLE:    ram_addr = PAL_AW'(in_entry);
			S_RD_CUR:  ram_addr = cur_q;
			S_RD_PREV: ram_addr = prev_q;
			S_SEARCH:  ram_addr = idx_q;
			default:   ram_addr = '0;
		endcase
	end

	pbpm_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Pixel context
	logic             pix_ok_q;
	logic [RGB_W-1:0] c1_q, c2_q;
	logic             cur_ok, prev_ok;

	assign cur_ok  = !in_cur[0] && ({1'b0, in_cur} < (IDX_W + 1)'(PALETTE_ENTRIES));
	assign prev_ok = !in_prev[0] && ({1'b0, in_prev} < (IDX_W + 1)'(PALETTE_ENTRIES));

	// Shared multiplier: channel weighting, then reciprocal divide
	logic [1:0]         ch_q;
	logic [CHAN_W-1:0]  a_chan, b_chan, hi_chan, lo_chan, diff_chan;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [PROD_W-1:0]  prod_q;

	assign a_chan    = chan_of(c1_q, ch_q);
	assign b_chan    = chan_of(c2_q, ch_q);
	assign hi_chan   = (a_chan > b_chan) ? a_chan : b_chan;
	assign lo_chan   = (a_chan > b_chan) ? b_chan : a_chan;
	assign diff_chan = hi_chan - lo_chan;

	always_comb begin
		if (state_q == S_DIV) begin
			mul_a = prod_q[MUL_A_W-1:0];
			mul_b = DIV_MULT;
		end else begin
			mul_a = MUL_A_W'(diff_chan);
			mul_b = MUL_B_W'(blend_percent_q);
		end
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Add back the darker value, saturate, quantize
	logic [QUOT_W-1:0] quot;
	logic [QUOT_W:0]   blend_sum;
	logic [CHAN_W-1:0] blend_val;

	assign quot      = prod_q[DIV_SHIFT +: QUOT_W];
	assign blend_sum = (QUOT_W + 1)'(quot) + (QUOT_W + 1)'(lo_chan);
	assign blend_val = ((blend_sum > (QUOT_W + 1)'(CHAN_MAX)) ? CHAN_MAX :
		blend_sum[CHAN_W-1:0]) & QUANT_MASK;

	logic [CHAN_W-1:0] red_q, green_q, blue_q;

	// Distance compare, one palette entry behind the address
	logic              cmp_vld_s1;
	logic [PAL_AW-1:0] cmp_idx_s1;
	logic [DIST_W-1:0] entry_dist;
	logic [DIST_W-1:0] best_q;
	logic [PAL_AW-1:0] best_idx_q;

	assign entry_dist = DIST_W'(abs_diff(ram_rdata[23:16], red_q)) +
		DIST_W'(abs_diff(ram_rdata[15:8], green_q)) +
		DIST_W'(abs_diff(ram_rdata[7:0], blue_q));

	// Output register
	logic              out_vld_q;
	logic [IDX_W-1:0]  colour_q;
	logic              out_free;

	assign out_free = !out_vld_q || m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = colour_q;

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && (in_op == OP_PIXEL)) begin
					state_d = S_RD_CUR;
				end
			end
			S_RD_CUR:  state_d = S_RD_PREV;
			S_RD_PREV: state_d = S_LATCH;
			S_LATCH:   state_d = S_MUL;
			S_MUL:     state_d = S_DIV;
			S_DIV:     state_d = S_ACC;
			S_ACC:     state_d = (ch_q == CH_BLUE) ? S_SEARCH : S_MUL;
			S_SEARCH: begin
				if (idx_q == PAL_AW'(LAST_EVEN)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == S_SEARCH);
			if (state_q == S_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cur_q    <= PAL_AW'(in_cur);
				prev_q   <= PAL_AW'(in_prev);
				pix_ok_q <= cur_ok && prev_ok;
				ch_q     <= CH_RED;
			end
			S_RD_PREV: c1_q <= ram_rdata;
			S_LATCH:   c2_q <= ram_rdata;
			S_MUL:     prod_q <= mul_p;
			S_DIV:     prod_q <= mul_p;
			S_ACC: begin
				unique case (ch_q)
					CH_RED:   red_q   <= pix_ok_q ? blend_val : '0;
					CH_GREEN: green_q <= pix_ok_q ? blend_val : '0;
					default:  blue_q  <= pix_ok_q ? blend_val : '0;
				endcase
				ch_q   <= ch_q + 2'd1;
				idx_q  <= '0;
				best_q <= DIST_START;
			end
			S_SEARCH: begin
				idx_q <= idx_q + PAL_AW'(2);
			end
			S_DONE: begin
				if (out_free) begin
					colour_q <= IDX_W'(best_idx_q);
				end
			end
			default: begin
			end
		endcase

		cmp_idx_s1 <= idx_q;
		if (cmp_vld_s1 && (entry_dist < best_q)) begin
			best_q     <= entry_dist;
			best_idx_q <= cmp_idx_s1;
		end
	end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for phosphor_blend_palette_match: a scoreboard class predicts
// the nearest even palette index for every pixel request. Depends on pbpm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import pbpm_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 6;
	localparam int SETTLE_CYCLES  = 200;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	localparam int PHASE_ITEMS    = 100;
	localparam int NUM_SETTINGS   = 6;
	localparam int REPORT_LIMIT   = 10;

	// Channel values left after quantization drops the low bits
	localparam logic [CHAN_W-1:0] KEEP_MASK = CHAN_W'(8'hFF << QUANT_SHIFT);

	// Request payload, last field in the lowest bits
	typedef struct packed {
		logic [7:0] previous_index;
		logic [7:0] current_index;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] entry_index;
	} palette_req_t;

	// Predicts colour indices and compares them with what the block returns
	class colour_scoreboard;
		logic [RGB_W-1:0] palette [PALETTE_ENTRIES];
		logic [CFG_W-1:0] blend_percent;
		logic [IDX_W-1:0] expected_colours [$];
		int               failures;
		int               checked;

		function new();
			foreach (palette[i])
				palette[i] = '0;
			blend_percent = BLEND_RESET;
			failures = 0;
			checked = 0;
		endfunction

		function void set_blend(input logic [CFG_W-1:0] value);
			blend_percent = value;
		endfunction

		function int pending();
			return expected_colours.size();
		endfunction

		// Blend toward the brighter value, saturate, then quantize
		function logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
				input logic [CHAN_W-1:0] b);
			int hi;
			int lo;
			int v;
			hi = (a > b) ? int'(a) : int'(b);
			lo = (a > b) ? int'(b) : int'(a);
			v = ((hi - lo) * int'(blend_percent)) / 100 + lo;
			if (v > 255)
				v = 255;
			return CHAN_W'(v) & KEEP_MASK;
		endfunction

		function logic [IDX_W-1:0] nearest_even(input logic [CHAN_W-1:0] r,
				input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
			int best;
			int best_idx;
			int d;
			logic [RGB_W-1:0] p;
			best = 256 * 3 + 1;
			best_idx = 0;
			for (int i = 0; i < PALETTE_ENTRIES; i += 2) begin
				p = palette[i];
				d = ((p[23:16] > r) ? int'(p[23:16] - r) : int'(r - p[23:16])) +
					((p[15:8] > g) ? int'(p[15:8] - g) : int'(g - p[15:8])) +
					((p[7:0] > b) ? int'(p[7:0] - b) : int'(b - p[7:0]));
				if (d < best) begin
					best = d;
					best_idx = i;
				end
			end
			return IDX_W'(best_idx);
		endfunction

		// Called for every accepted request
		function void note_request(input logic op, input palette_req_t req);
			logic [RGB_W-1:0] c1;
			logic [RGB_W-1:0] c2;
			logic [CHAN_W-1:0] r;
			logic [CHAN_W-1:0] g;
			logic [CHAN_W-1:0] b;
			if (op == OP_WRITE) begin
				if (int'(req.entry_index) < PALETTE_ENTRIES)
					palette[req.entry_index] = {req.red, req.green, req.blue};
				return;
			end
			r = '0;
			g = '0;
			b = '0;
			// odd or out-of-range index: blended colour is black
			if (!req.current_index[0] && !req.previous_index[0] &&
					int'(req.current_index) < PALETTE_ENTRIES &&
					int'(req.previous_index) < PALETTE_ENTRIES) begin
				c1 = palette[req.current_index];
				c2 = palette[req.previous_index];
				r = mix_channel(c1[23:16], c2[23:16]);
				g = mix_channel(c1[15:8], c2[15:8]);
				b = mix_channel(c1[7:0], c2[7:0]);
			end
			expected_colours.push_back(nearest_even(r, g, b));
		endfunction

		// Called for every accepted result
		function void check_colour(input logic [IDX_W-1:0] got);
			logic [IDX_W-1:0] want;
			if (expected_colours.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: colour_index=%0d", got);
				return;
			end
			want = expected_colours.pop_front();
			checked++;
			if (got !== want) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("colour_index mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	colour_scoreboard board;
	bit               steady;     // no idling on either side while set
	int               n_writes;
	int               n_pixels;
	int               n_black;
	int               n_settings;

	phosphor_blend_palette_match dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(input int long_max);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, long_max);
	endfunction

	function automatic logic [7:0] pick_channel();
		logic [7:0] corners [6];
		corners = '{8'h00, 8'h04, 8'h40, 8'h80, 8'hFC, 8'hFF};
		if ($urandom_range(0, 9) < 4)
			return corners[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	// Result side: random back-pressure, check every accepted result
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_colour(m_tdata);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = pick_gap(180);
				m_tready <= (stall == 0);
			end
		end
	end

	// Present one request and hold it until taken
	task automatic send_request(input logic op, input palette_req_t req);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= req;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(op, req);
		if (op == OP_WRITE) begin
			n_writes++;
		end else begin
			n_pixels++;
			if (req.current_index[0] || req.previous_index[0])
				n_black++;
		end
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic write_entry(input logic [7:0] idx, input logic [23:0] rgb);
		palette_req_t req;
		req = palette_req_t'($urandom_range(0, 32'hFFFF_FFFF));
		req.previous_index = 8'($urandom_range(0, 255));
		req.current_index = 8'($urandom_range(0, 255));
		req.entry_index = idx;
		{req.red, req.green, req.blue} = rgb;
		send_request(OP_WRITE, req);
		idle_sender(pick_gap(40));
	endtask

	task automatic send_pixel(input logic [7:0] cur, input logic [7:0] prev);
		palette_req_t req;
		req = palette_req_t'($urandom_range(0, 32'hFFFF_FFFF));
		req.current_index = cur;
		req.previous_index = prev;
		send_request(OP_PIXEL, req);
		idle_sender(pick_gap(40));
	endtask

	// Sender holds off until every expected result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Register write only while idle; the last write may still be in flight
	task automatic set_blend(input logic [CFG_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		board.set_blend(value);
		n_settings++;
	endtask

	// One random request: mostly even pixels, some writes, some odd-index noise
	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 3)
			steady = !steady;
		if (r < 18)
			write_entry(8'($urandom_range(0, 255)),
				{pick_channel(), pick_channel(), pick_channel()});
		else if (r < 28)
			send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)) | 8'd1);
		else
			send_pixel(8'($urandom_range(0, 127)) << 1, 8'($urandom_range(0, 127)) << 1);
	endtask

	initial begin
		logic [CFG_W-1:0] settings [NUM_SETTINGS];
		board = new();
		steady = 1'b0;
		n_writes = 0;
		n_pixels = 0;
		n_black = 0;
		n_settings = 0;
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_WRITE;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole palette before any pixel reads it
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			write_entry(8'(i), {pick_channel(), pick_channel(), pick_channel()});

		// Directed: ties, extremes of index and colour, odd indices
		write_entry(8'd0, 24'h000000);
		write_entry(8'd2, 24'h000000);
		write_entry(8'd4, 24'hFFFFFF);
		write_entry(8'd6, 24'hFFFFFF);
		write_entry(8'd254, 24'hFF00FF);
		write_entry(8'd255, 24'h00FF00);
		write_entry(8'd1, 24'h123456);
		send_pixel(8'd0, 8'd0);
		send_pixel(8'd4, 8'd4);
		send_pixel(8'd0, 8'd4);
		send_pixel(8'd4, 8'd0);
		send_pixel(8'd1, 8'd0);
		send_pixel(8'd0, 8'd1);
		send_pixel(8'd255, 8'd255);
		send_pixel(8'd254, 8'd254);
		send_pixel(8'd254, 8'd0);
		send_pixel(8'd0, 8'd254);
		send_pixel(8'd254, 8'd4);
		send_pixel(8'd254, 8'd255);

		// Random phases over several blend settings, extremes included
		settings = '{8'd0, 8'd255, 8'd100, 8'd1, 8'($urandom_range(2, 254)), BLEND_RESET};
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			set_blend(settings[s]);
			write_entry(8'd0, 24'h000000);
			send_pixel(8'd4, 8'd254);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2)
					wait_drained();
				random_request();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			board.failures += board.pending();
			$display("%0d expected results never arrived", board.pending());
		end
		$display("covered %0d palette writes and %0d pixels (%0d with an odd index)",
			n_writes, n_pixels, n_black);
		$display("over %0d blend settings; %0d results checked, %0d failures",
			n_settings + 1, board.checked, board.failures);
		if (board.failures == 0)
			$display("phosphor_blend_palette_match regression: pass");
		else
			$display("phosphor_blend_palette_match regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("timeout with %0d results outstanding", board.pending());
		$display("phosphor_blend_palette_match regression: fail");
		$finish;
	end

endmodule

/* files.f */
design/pbpm_pkg.sv
design/pbpm_ram.sv
design/phosphor_blend_palette_match.sv
tb/testbench.sv
